// ----- design/dsf_pkg.sv -----
// Shared constants, widths and types of the damped spring force block.
// Depends on nothing; every other file of the block refers to it by scoped names.
package dsf_pkg;

  // Fixed point format of all positions, velocities, registers and forces.
  localparam int FRAC_BITS = 16;

  // Field and datapath widths.
  localparam int IW    = 32;                 // input and output field width
  localparam int DW    = IW + 1;             // node difference width
  localparam int LW    = DW;                 // spring length width
  localparam int SUMW  = 2 * DW;             // squared length width
  localparam int QW    = FRAC_BITS + 1;      // unit direction magnitude width
  localparam int UW    = FRAC_BITS + 2;      // signed unit direction width
  localparam int RW    = LW + 1;             // divider remainder width
  localparam int EXTW  = LW + 2;             // extension (length minus rest) width
  localparam int PW    = UW + DW;            // direction times velocity width
  localparam int DOTW  = PW + 2;             // projected velocity sum width
  localparam int PROJW = DOTW - FRAC_BITS;
  localparam int M1W   = IW + 1 + EXTW;
  localparam int M2W   = IW + 1 + PROJW;
  localparam int ACCW  = ((M1W > M2W) ? M1W : M2W) + 1;
  localparam int SHW   = ACCW - FRAC_BITS;
  localparam int SW    = IW + FRAC_BITS + 2; // limited scalar force width
  localparam int CLW   = (SHW > SW) ? SHW : SW;
  localparam int FPW   = SW + UW;
  localparam int FSHW  = FPW - FRAC_BITS;

  // Limit of the scalar force before it scales the direction.
  localparam logic signed [CLW-1:0] S_LIM   = CLW'(1) <<< (IW + FRAC_BITS);
  localparam logic signed [CLW-1:0] S_LIM_N = -S_LIM;

  // Configuration register map.
  localparam int AW = 4;
  localparam logic [1:0] REG_STIFFNESS   = 2'd0;
  localparam logic [1:0] REG_DAMPING     = 2'd1;
  localparam logic [1:0] REG_REST_LENGTH = 2'd2;

  localparam logic [IW-1:0] STIFFNESS_RST   = IW'(200 << FRAC_BITS);
  localparam logic [IW-1:0] DAMPING_RST     = IW'(200 << FRAC_BITS);
  localparam logic [IW-1:0] REST_LENGTH_RST = IW'(((85 << FRAC_BITS) + 50) / 100);

  // One spring request as it enters the block.
  typedef struct packed {
    logic signed [IW-1:0] pos_a_x;
    logic signed [IW-1:0] pos_a_y;
    logic signed [IW-1:0] pos_a_z;
    logic signed [IW-1:0] pos_b_x;
    logic signed [IW-1:0] pos_b_y;
    logic signed [IW-1:0] pos_b_z;
    logic signed [IW-1:0] vel_a_x;
    logic signed [IW-1:0] vel_a_y;
    logic signed [IW-1:0] vel_a_z;
    logic signed [IW-1:0] vel_b_x;
    logic signed [IW-1:0] vel_b_y;
    logic signed [IW-1:0] vel_b_z;
  } item_t;

  // Separation and velocity difference vectors, two's complement lanes.
  typedef struct packed {
    logic [2:0][DW-1:0] d;
    logic [2:0][DW-1:0] dv;
  } vec_t;

  // One stage of the square root pipeline.
  typedef struct packed {
    logic [SUMW-1:0] rad;
    logic [LW+1:0]   rem;
    logic [LW-1:0]   root;
    vec_t            side;
  } sq_t;

  // Data that rides along the divider lanes.
  typedef struct packed {
    logic [2:0][DW-1:0] dv;
    logic [2:0]         neg;
    logic [EXTW-1:0]    ext;
    logic               zero;
  } div_side_t;

  // One stage of the direction divider.
  typedef struct packed {
    logic [2:0][RW-1:0] r;
    logic [2:0][QW-1:0] q;
    logic [LW-1:0]      len;
    div_side_t          side;
  } div_t;

  // One result.
  typedef struct packed {
    logic signed [IW-1:0] force_x;
    logic signed [IW-1:0] force_y;
    logic signed [IW-1:0] force_z;
    logic                 zero_length;
    logic                 saturated;
  } res_t;

endpackage

// ----- design/dsf_if.sv -----
// Valid/ready channel interfaces of the damped spring force block.
// Depends on dsf_pkg for the field width.
interface dsf_in_if;
  logic valid;
  logic ready;
  logic signed [dsf_pkg::IW-1:0] pos_a_x;
  logic signed [dsf_pkg::IW-1:0] pos_a_y;
  logic signed [dsf_pkg::IW-1:0] pos_a_z;
  logic signed [dsf_pkg::IW-1:0] pos_b_x;
  logic signed [dsf_pkg::IW-1:0] pos_b_y;
  logic signed [dsf_pkg::IW-1:0] pos_b_z;
  logic signed [dsf_pkg::IW-1:0] vel_a_x;
  logic signed [dsf_pkg::IW-1:0] vel_a_y;
  logic signed [dsf_pkg::IW-1:0] vel_a_z;
  logic signed [dsf_pkg::IW-1:0] vel_b_x;
  logic signed [dsf_pkg::IW-1:0] vel_b_y;
  logic signed [dsf_pkg::IW-1:0] vel_b_z;

  modport source (output valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
                  vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z, input ready);
  modport sink (input valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
                vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z, output ready);
endinterface

interface dsf_out_if;
  logic valid;
  logic ready;
  logic signed [dsf_pkg::IW-1:0] force_x;
  logic signed [dsf_pkg::IW-1:0] force_y;
  logic signed [dsf_pkg::IW-1:0] force_z;
  logic zero_length;
  logic saturated;

  modport source (output valid, force_x, force_y, force_z, zero_length, saturated,
                  input ready);
  modport sink (input valid, force_x, force_y, force_z, zero_length, saturated,
                output ready);
endinterface

// ----- design/dsf_front.sv -----
// Front stages: node differences, squared components and squared length.
// Depends on dsf_pkg; three register stages that advance on en.
module dsf_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_v,
  input  dsf_pkg::item_t            item,
  output logic                      out_v,
  output logic [dsf_pkg::SUMW-1:0]  sum,
  output dsf_pkg::vec_t             vec_out
);

  localparam int IW   = dsf_pkg::IW;
  localparam int DW   = dsf_pkg::DW;
  localparam int SUMW = dsf_pkg::SUMW;

  logic [2:0][IW-1:0]   pa, pb, va, vb;
  logic [2:0]           v_r;
  dsf_pkg::vec_t        s0_vec_r, s0_vec_nxt;
  dsf_pkg::vec_t        s1_vec_r;
  dsf_pkg::vec_t        s2_vec_r;
  logic [2:0][SUMW-1:0] s1_sq_r, s1_sq_nxt;
  logic [SUMW-1:0]      s2_sum_r, s2_sum_nxt;
  logic [2:0][DW-1:0]   mag;

  assign pa = {item.pos_a_z, item.pos_a_y, item.pos_a_x};
  assign pb = {item.pos_b_z, item.pos_b_y, item.pos_b_x};
  assign va = {item.vel_a_z, item.vel_a_y, item.vel_a_x};
  assign vb = {item.vel_b_z, item.vel_b_y, item.vel_b_x};

  // Stage 0: exact differences, sign extended by one bit.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s0_vec_nxt.d[i]  = {pa[i][IW-1], pa[i]} - {pb[i][IW-1], pb[i]};
      s0_vec_nxt.dv[i] = {va[i][IW-1], va[i]} - {vb[i][IW-1], vb[i]};
    end
  end

  // Stage 1: square of each separation magnitude.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i]       = s0_vec_r.d[i][DW-1] ? (~s0_vec_r.d[i] + 1'b1) : s0_vec_r.d[i];
      s1_sq_nxt[i] = SUMW'(mag[i]) * SUMW'(mag[i]);
    end
  end

  // Stage 2: squared length.
  assign s2_sum_nxt = s1_sq_r[0] + s1_sq_r[1] + s1_sq_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_vec_r <= s0_vec_nxt;
      s1_vec_r <= s0_vec_r;
      s1_sq_r  <= s1_sq_nxt;
      s2_vec_r <= s1_vec_r;
      s2_sum_r <= s2_sum_nxt;
    end
  end

  assign out_v   = v_r[2];
  assign sum     = s2_sum_r;
  assign vec_out = s2_vec_r;

endmodule

// ----- design/dsf_sqrt.sv -----
// Pipelined integer square root, one result bit per register stage.
// Depends on dsf_pkg; the vectors of the request travel alongside.
module dsf_sqrt (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_v,
  input  logic [dsf_pkg::SUMW-1:0] sum,
  input  dsf_pkg::vec_t            vec_in,
  output logic                     out_v,
  output logic [dsf_pkg::LW-1:0]   len,
  output dsf_pkg::vec_t            vec_out
);

  localparam int N    = dsf_pkg::LW;
  localparam int SUMW = dsf_pkg::SUMW;

  // One digit step: bring down two radicand bits and try the next root bit.
  function automatic dsf_pkg::sq_t sq_step(input dsf_pkg::sq_t x);
    dsf_pkg::sq_t y;
    logic [N+1:0] rem_sh;
    logic [N+1:0] trial;
    y      = x;
    rem_sh = {x.rem[N-1:0], x.rad[SUMW-1 -: 2]};
    trial  = {x.root, 2'b01};
    if (rem_sh >= trial) begin
      y.rem  = rem_sh - trial;
      y.root = {x.root[N-2:0], 1'b1};
    end else begin
      y.rem  = rem_sh;
      y.root = {x.root[N-2:0], 1'b0};
    end
    y.rad = {x.rad[SUMW-3:0], 2'b00};
    return y;
  endfunction

  logic [N-1:0] v_r;
  dsf_pkg::sq_t st_r   [N];
  dsf_pkg::sq_t st_nxt [N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[N-2:0], in_v};
    end
  end

  // Root stages, most significant bit first.
  for (genvar k = 0; k < N; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign st_nxt[k] = sq_step('{rad: sum, rem: '0, root: '0, side: vec_in});
    end else begin : g_rest
      assign st_nxt[k] = sq_step(st_r[k-1]);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign out_v   = v_r[N-1];
  assign len     = st_r[N-1].root;
  assign vec_out = st_r[N-1].side;

endmodule

// ----- design/dsf_div.sv -----
// Pipelined restoring divider for the unit direction, three lanes in step.
// Depends on dsf_pkg; one quotient bit per register stage.
module dsf_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_v,
  input  logic [dsf_pkg::LW-1:0]           len,
  input  dsf_pkg::vec_t                    vec_in,
  input  logic [dsf_pkg::IW-1:0]           rest_length,
  output logic                             out_v,
  output logic [2:0][dsf_pkg::QW-1:0]      q,
  output dsf_pkg::div_side_t               side
);

  localparam int QW   = dsf_pkg::QW;
  localparam int RW   = dsf_pkg::RW;
  localparam int DW   = dsf_pkg::DW;
  localparam int EXTW = dsf_pkg::EXTW;

  // One quotient bit per lane; the first step compares without a shift.
  function automatic dsf_pkg::div_t div_step(input dsf_pkg::div_t x, input logic first);
    dsf_pkg::div_t y;
    logic [RW-1:0] rs;
    y = x;
    for (int i = 0; i < 3; i++) begin
      rs = first ? x.r[i] : {x.r[i][RW-2:0], 1'b0};
      if (rs >= {1'b0, x.len}) begin
        y.r[i] = rs - {1'b0, x.len};
        y.q[i] = {x.q[i][QW-2:0], 1'b1};
      end else begin
        y.r[i] = rs;
        y.q[i] = {x.q[i][QW-2:0], 1'b0};
      end
    end
    return y;
  endfunction

  dsf_pkg::div_t entry;
  logic [QW-1:0] v_r;
  dsf_pkg::div_t st_r   [QW];
  dsf_pkg::div_t st_nxt [QW];

  // Separation magnitudes become the dividends; extension and flags join here.
  always_comb begin
    entry = '0;
    for (int i = 0; i < 3; i++) begin
      entry.r[i]        = vec_in.d[i][DW-1] ? {1'b0, ~vec_in.d[i] + 1'b1}
                                            : {1'b0, vec_in.d[i]};
      entry.side.dv[i]  = vec_in.dv[i];
      entry.side.neg[i] = vec_in.d[i][DW-1];
    end
    entry.len       = len;
    entry.side.ext  = EXTW'(len) - EXTW'(rest_length);
    entry.side.zero = (len == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[QW-2:0], in_v};
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign st_nxt[k] = div_step(entry, 1'b1);
    end else begin : g_rest
      assign st_nxt[k] = div_step(st_r[k-1], 1'b0);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign out_v = v_r[QW-1];
  assign q     = st_r[QW-1].q;
  assign side  = st_r[QW-1].side;

endmodule

// ----- design/dsf_force.sv -----
// Back stages: velocity projection, scalar spring force and force components.
// Depends on dsf_pkg; six register stages, a multiplier level in stages 0, 2 and 4.
module dsf_force (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_v,
  input  logic [2:0][dsf_pkg::QW-1:0]   q,
  input  dsf_pkg::div_side_t            side,
  input  logic [dsf_pkg::IW-1:0]        stiffness,
  input  logic [dsf_pkg::IW-1:0]        damping,
  output logic                          out_v,
  output dsf_pkg::res_t                 res
);

  localparam int F     = dsf_pkg::FRAC_BITS;
  localparam int IW    = dsf_pkg::IW;
  localparam int UW    = dsf_pkg::UW;
  localparam int PW    = dsf_pkg::PW;
  localparam int EXTW  = dsf_pkg::EXTW;
  localparam int DOTW  = dsf_pkg::DOTW;
  localparam int PROJW = dsf_pkg::PROJW;
  localparam int M1W   = dsf_pkg::M1W;
  localparam int M2W   = dsf_pkg::M2W;
  localparam int ACCW  = dsf_pkg::ACCW;
  localparam int SHW   = dsf_pkg::SHW;
  localparam int SW    = dsf_pkg::SW;
  localparam int CLW   = dsf_pkg::CLW;
  localparam int FPW   = dsf_pkg::FPW;
  localparam int FSHW  = dsf_pkg::FSHW;

  logic [5:0] v_r;

  logic [2:0][UW-1:0]     b0_u_r, b0_u_nxt;
  logic [2:0][PW-1:0]     b0_p_r, b0_p_nxt;
  logic [EXTW-1:0]        b0_ext_r;
  logic                   b0_zero_r;

  logic [2:0][UW-1:0]     b1_u_r;
  logic signed [DOTW-1:0] b1_dot_r, b1_dot_nxt;
  logic [EXTW-1:0]        b1_ext_r;
  logic                   b1_zero_r;

  logic [2:0][UW-1:0]     b2_u_r;
  logic signed [M1W-1:0]  b2_m1_r, b2_m1_nxt;
  logic signed [M2W-1:0]  b2_m2_r, b2_m2_nxt;
  logic                   b2_zero_r;
  logic signed [PROJW-1:0] proj;

  logic [2:0][UW-1:0]     b3_u_r;
  logic signed [SW-1:0]   b3_s_r, b3_s_nxt;
  logic                   b3_zero_r;
  logic signed [ACCW-1:0] acc;
  logic signed [SHW-1:0]  acc_sh;
  logic signed [CLW-1:0]  acc_w;

  logic [2:0][FPW-1:0]    b4_fp_r, b4_fp_nxt;
  logic                   b4_zero_r;

  dsf_pkg::res_t          b5_res_r, b5_res_nxt;
  logic [2:0][FSHW-1:0]   fs;
  logic [2:0][IW-1:0]     fc;
  logic [2:0]             clip;

  // Stage 0: signed direction and its product with the velocity difference.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      b0_u_nxt[i] = side.neg[i] ? UW'(0) - UW'(q[i]) : UW'(q[i]);
      b0_p_nxt[i] = $signed(b0_u_nxt[i]) * $signed(side.dv[i]);
    end
  end

  // Stage 1: dot product.
  assign b1_dot_nxt = DOTW'($signed(b0_p_r[0])) + DOTW'($signed(b0_p_r[1]))
                    + DOTW'($signed(b0_p_r[2]));

  // Stage 2: spring and damper terms; the floor shift is an arithmetic part-select.
  assign proj      = $signed(b1_dot_r[DOTW-1:F]);
  assign b2_m1_nxt = $signed({1'b0, stiffness}) * $signed(b1_ext_r);
  assign b2_m2_nxt = $signed({1'b0, damping}) * proj;

  // Stage 3: scalar force, floored and limited.
  always_comb begin
    acc    = ACCW'(b2_m1_r) + ACCW'(b2_m2_r);
    acc_sh = $signed(acc[ACCW-1:F]);
    acc_w  = CLW'(acc_sh);
    if (acc_w > dsf_pkg::S_LIM) begin
      b3_s_nxt = dsf_pkg::S_LIM[SW-1:0];
    end else if (acc_w < dsf_pkg::S_LIM_N) begin
      b3_s_nxt = dsf_pkg::S_LIM_N[SW-1:0];
    end else begin
      b3_s_nxt = acc_w[SW-1:0];
    end
  end

  // Stage 4: scale the direction.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      b4_fp_nxt[i] = b3_s_r * $signed(b3_u_r[i]);
    end
  end

  // Stage 5: floor shift, clip to 32 bits, zero length override.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fs[i] = b4_fp_r[i][FPW-1:F];
      if ((&fs[i][FSHW-1:IW-1]) || !(|fs[i][FSHW-1:IW-1])) begin
        fc[i]   = fs[i][IW-1:0];
        clip[i] = 1'b0;
      end else begin
        fc[i]   = fs[i][FSHW-1] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
        clip[i] = 1'b1;
      end
    end
    if (b4_zero_r) begin
      b5_res_nxt = '0;
      b5_res_nxt.zero_length = 1'b1;
    end else begin
      b5_res_nxt.force_x     = fc[0];
      b5_res_nxt.force_y     = fc[1];
      b5_res_nxt.force_z     = fc[2];
      b5_res_nxt.zero_length = 1'b0;
      b5_res_nxt.saturated   = |clip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b0_u_r    <= b0_u_nxt;
      b0_p_r    <= b0_p_nxt;
      b0_ext_r  <= side.ext;
      b0_zero_r <= side.zero;
      b1_u_r    <= b0_u_r;
      b1_dot_r  <= b1_dot_nxt;
      b1_ext_r  <= b0_ext_r;
      b1_zero_r <= b0_zero_r;
      b2_u_r    <= b1_u_r;
      b2_m1_r   <= b2_m1_nxt;
      b2_m2_r   <= b2_m2_nxt;
      b2_zero_r <= b1_zero_r;
      b3_u_r    <= b2_u_r;
      b3_s_r    <= b3_s_nxt;
      b3_zero_r <= b2_zero_r;
      b4_fp_r   <= b4_fp_nxt;
      b4_zero_r <= b3_zero_r;
      b5_res_r  <= b5_res_nxt;
    end
  end

  assign out_v = v_r[5];
  assign res   = b5_res_r;

endmodule

// ----- design/damped_spring_force.sv -----
// Damped spring force top level: configuration registers, pipeline and output.
// Depends on dsf_pkg, dsf_if, dsf_front, dsf_sqrt, dsf_div and dsf_force.
//
// Usage: each request on in_chan carries the positions and velocities of the
// two end nodes of one spring; each result on out_chan carries the 3D spring
// force in signed Q16.16 with a zero length flag and a saturation flag.
// Both channels use valid/ready; a request moves on an edge where both are high.
// Stiffness, damping and rest length are written over the APB-style port at
// byte addresses 0, 4 and 8; the user must do so only while no request is in
// flight (the block itself does not enforce it); reads return them. Throughput is
// one request per cycle while the skid register is empty. A request passes
// 3 front stages, one square root stage per length bit (33), one divider stage
// per quotient bit (FRAC_BITS + 1), 6 force stages and the output register.
// When the receiver stalls, the output register holds its result and one more
// result lands in a skid register; then in_chan.ready drops and the whole
// pipeline freezes in place, so nothing is lost or repeated.
// A synchronous reset empties the pipeline and restores the default
// stiffness 200.0, damping 200.0 and rest length 0.85, all in Q16.16.
module damped_spring_force (
  input  logic                       clk,
  input  logic                       rst_n,
  dsf_in_if.sink                     in_chan,
  dsf_out_if.source                  out_chan,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dsf_pkg::AW-1:0]     paddr,
  input  logic [dsf_pkg::IW-1:0]     pwdata,
  output logic [dsf_pkg::IW-1:0]     prdata,
  output logic                       pready
);

  localparam int IW   = dsf_pkg::IW;
  localparam int AW   = dsf_pkg::AW;
  localparam int LW   = dsf_pkg::LW;
  localparam int QW   = dsf_pkg::QW;
  localparam int SUMW = dsf_pkg::SUMW;

  logic [IW-1:0] stiffness_r, damping_r, rest_length_r;
  logic [1:0]    reg_idx;
  logic          cfg_wr;

  dsf_pkg::item_t        item;
  logic                  en;
  logic                  front_v, sqrt_v, div_v, pipe_v;
  logic [SUMW-1:0]       front_sum;
  dsf_pkg::vec_t         front_vec, sqrt_vec;
  logic [LW-1:0]         sqrt_len;
  logic [2:0][QW-1:0]    div_q;
  dsf_pkg::div_side_t    div_side;
  dsf_pkg::res_t         pipe_res;

  logic                  out_v_r, out_v_nxt;
  logic                  skid_v_r, skid_v_nxt;
  dsf_pkg::res_t         out_r, out_nxt;
  dsf_pkg::res_t         skid_r, skid_nxt;
  logic                  take, push;

  // Configuration port: writes complete in the access cycle, no wait states.
  assign pready  = 1'b1;
  assign reg_idx = paddr[AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiffness_r   <= dsf_pkg::STIFFNESS_RST;
      damping_r     <= dsf_pkg::DAMPING_RST;
      rest_length_r <= dsf_pkg::REST_LENGTH_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        dsf_pkg::REG_STIFFNESS:   stiffness_r   <= pwdata;
        dsf_pkg::REG_DAMPING:     damping_r     <= pwdata;
        dsf_pkg::REG_REST_LENGTH: rest_length_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dsf_pkg::REG_STIFFNESS:   prdata = stiffness_r;
      dsf_pkg::REG_DAMPING:     prdata = damping_r;
      dsf_pkg::REG_REST_LENGTH: prdata = rest_length_r;
      default:                  prdata = '0;
    endcase
  end

  // The pipeline advances whenever the skid register is free.
  assign en            = !skid_v_r;
  assign in_chan.ready = en;

  always_comb begin
    item.pos_a_x = in_chan.pos_a_x;
    item.pos_a_y = in_chan.pos_a_y;
    item.pos_a_z = in_chan.pos_a_z;
    item.pos_b_x = in_chan.pos_b_x;
    item.pos_b_y = in_chan.pos_b_y;
    item.pos_b_z = in_chan.pos_b_z;
    item.vel_a_x = in_chan.vel_a_x;
    item.vel_a_y = in_chan.vel_a_y;
    item.vel_a_z = in_chan.vel_a_z;
    item.vel_b_x = in_chan.vel_b_x;
    item.vel_b_y = in_chan.vel_b_y;
    item.vel_b_z = in_chan.vel_b_z;
  end

  dsf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (in_chan.valid),
    .item    (item),
    .out_v   (front_v),
    .sum     (front_sum),
    .vec_out (front_vec)
  );

  dsf_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (front_v),
    .sum     (front_sum),
    .vec_in  (front_vec),
    .out_v   (sqrt_v),
    .len     (sqrt_len),
    .vec_out (sqrt_vec)
  );

  dsf_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_v        (sqrt_v),
    .len         (sqrt_len),
    .vec_in      (sqrt_vec),
    .rest_length (rest_length_r),
    .out_v       (div_v),
    .q           (div_q),
    .side        (div_side)
  );

  dsf_force u_force (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_v      (div_v),
    .q         (div_q),
    .side      (div_side),
    .stiffness (stiffness_r),
    .damping   (damping_r),
    .out_v     (pipe_v),
    .res       (pipe_res)
  );

  // Output register with one skid entry behind it.
  assign take = out_v_r && out_chan.ready;
  assign push = en && pipe_v;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_nxt    = out_r;
    skid_nxt   = skid_r;
    if (take) begin
      if (skid_v_r) begin
        out_nxt    = skid_r;
        skid_v_nxt = 1'b0;
      end else if (push) begin
        out_nxt = pipe_res;
      end else begin
        out_v_nxt = 1'b0;
      end
    end else if (!out_v_r) begin
      if (push) begin
        out_nxt   = pipe_res;
        out_v_nxt = 1'b1;
      end
    end else if (push) begin
      skid_nxt   = pipe_res;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_chan.valid       = out_v_r;
  assign out_chan.force_x     = out_r.force_x;
  assign out_chan.force_y     = out_r.force_y;
  assign out_chan.force_z     = out_r.force_z;
  assign out_chan.zero_length = out_r.zero_length;
  assign out_chan.saturated   = out_r.saturated;

endmodule

// ----- tb/dsf_checker.sv -----
`timescale 1ns / 1ps
// Checker of the damped spring force block: watches both channels and the register port.
// Depends on dsf_pkg and dsf_if. It predicts each force and compares it with the block.
module dsf_checker (
  input  logic                   clk,
  input  logic                   rst_n,
  dsf_in_if                      in_mon,
  dsf_out_if                     out_mon,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic                   pready,
  input  logic [dsf_pkg::AW-1:0] paddr,
  input  logic [dsf_pkg::IW-1:0] pwdata,
  output int                     errors,
  output int                     pending
);

  typedef logic signed [127:0] wide_t;

  logic [dsf_pkg::IW-1:0] stiff_q, damp_q, rest_q;
  dsf_pkg::res_t          force_q[$];
  int                     mismatches;

  // Clip a wide value to [lo_lim, hi_lim] and flag the clipping.
  function automatic wide_t clip(wide_t v, wide_t lo_lim, wide_t hi_lim, ref logic hit);
    if (v > hi_lim) begin
      hit = 1'b1;
      return hi_lim;
    end
    if (v < lo_lim) begin
      hit = 1'b1;
      return lo_lim;
    end
    return v;
  endfunction

  // Expected force of one spring under the current stiffness, damping and rest length.
  function automatic dsf_pkg::res_t predict_force(dsf_pkg::item_t it);
    logic signed [dsf_pkg::DW-1:0] d[3], dv[3];
    logic [dsf_pkg::DW-1:0]        m[3];
    logic [65:0]                   sq, m66;
    logic [67:0]                   tt;
    logic [33:0]                   len, t;
    logic [48:0]                   q;
    wide_t                         u[3], dot, proj, ext, acc, s, f, lim, dvw;
    logic                          hit, dummy;
    dsf_pkg::res_t                 r;
    d[0]  = {it.pos_a_x[31], it.pos_a_x} - {it.pos_b_x[31], it.pos_b_x};
    d[1]  = {it.pos_a_y[31], it.pos_a_y} - {it.pos_b_y[31], it.pos_b_y};
    d[2]  = {it.pos_a_z[31], it.pos_a_z} - {it.pos_b_z[31], it.pos_b_z};
    dv[0] = {it.vel_a_x[31], it.vel_a_x} - {it.vel_b_x[31], it.vel_b_x};
    dv[1] = {it.vel_a_y[31], it.vel_a_y} - {it.vel_b_y[31], it.vel_b_y};
    dv[2] = {it.vel_a_z[31], it.vel_a_z} - {it.vel_b_z[31], it.vel_b_z};
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      m[i] = d[i][dsf_pkg::DW-1] ? -d[i] : d[i];
      m66  = m[i];
      sq  += m66 * m66;
    end
    // Bitwise square root, floor of the exact value.
    len = '0;
    for (int b = 33; b >= 0; b--) begin
      t  = len | (34'd1 << b);
      tt = t;
      if (tt * tt <= sq) len = t;
    end
    r = '0;
    if (len == 0) begin
      r.zero_length = 1'b1;
      return r;
    end
    dot = '0;
    for (int i = 0; i < 3; i++) begin
      q    = {m[i], 16'b0} / len;
      u[i] = $signed({79'b0, q});
      if (d[i][dsf_pkg::DW-1]) u[i] = -u[i];
      dvw  = dv[i];
      dot += u[i] * dvw;
    end
    proj  = dot >>> dsf_pkg::FRAC_BITS;
    ext   = $signed({94'b0, len}) - $signed({96'b0, rest_q});
    acc   = $signed({96'b0, stiff_q}) * ext + $signed({96'b0, damp_q}) * proj;
    lim   = wide_t'(1) <<< (dsf_pkg::IW + dsf_pkg::FRAC_BITS);
    dummy = 1'b0;
    s     = clip(acc >>> dsf_pkg::FRAC_BITS, -lim, lim, dummy);
    hit   = 1'b0;
    for (int i = 0; i < 3; i++) begin
      f = clip((s * u[i]) >>> dsf_pkg::FRAC_BITS, -(wide_t'(1) <<< 31),
               (wide_t'(1) <<< 31) - 1, hit);
      case (i)
        0: r.force_x = f[31:0];
        1: r.force_y = f[31:0];
        default: r.force_z = f[31:0];
      endcase
    end
    r.saturated = hit;
    return r;
  endfunction

  // Track register writes, predict accepted requests and check results.
  always @(posedge clk) begin
    dsf_pkg::item_t it;
    dsf_pkg::res_t  got, want;
    if (!rst_n) begin
      stiff_q    <= dsf_pkg::STIFFNESS_RST;
      damp_q     <= dsf_pkg::DAMPING_RST;
      rest_q     <= dsf_pkg::REST_LENGTH_RST;
      force_q.delete();
      errors     = 0;
      mismatches = 0;
      pending    <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[dsf_pkg::AW-1:2])
          dsf_pkg::REG_STIFFNESS:   stiff_q <= pwdata;
          dsf_pkg::REG_DAMPING:     damp_q  <= pwdata;
          dsf_pkg::REG_REST_LENGTH: rest_q  <= pwdata;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        it = '{in_mon.pos_a_x, in_mon.pos_a_y, in_mon.pos_a_z,
               in_mon.pos_b_x, in_mon.pos_b_y, in_mon.pos_b_z,
               in_mon.vel_a_x, in_mon.vel_a_y, in_mon.vel_a_z,
               in_mon.vel_b_x, in_mon.vel_b_y, in_mon.vel_b_z};
        force_q.push_back(predict_force(it));
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.force_x, out_mon.force_y, out_mon.force_z,
                out_mon.zero_length, out_mon.saturated};
        if (force_q.size() == 0) begin
          errors = errors + 1;
          if (mismatches < 10) $display("ERROR: result with no request pending: %p", got);
          mismatches = mismatches + 1;
        end else begin
          want = force_q.pop_front();
          if (got !== want) begin
            errors = errors + 1;
            if (mismatches < 10)
              $display("ERROR: force mismatch at %0t: expected %p, got %p", $realtime, want, got);
            mismatches = mismatches + 1;
          end
        end
      end
      pending <= force_q.size();
    end
  end
endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench top of the damped spring force block: clock, reset, stimulus and verdict.
// Depends on dsf_pkg, dsf_if, the block itself and dsf_checker.
module tb_top;

  localparam int LATENCY  = 60;
  localparam int WDOG_MAX = 5000;
  localparam logic [dsf_pkg::AW-1:0] SPARE_ADDR = dsf_pkg::AW'(12);

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [dsf_pkg::AW-1:0] paddr = '0;
  logic [dsf_pkg::IW-1:0] pwdata = '0;
  logic [dsf_pkg::IW-1:0] prdata;
  logic                   pready;
  logic                   in_fire = 1'b0;
  logic                   quiet = 1'b0;
  logic                   long_hold = 1'b0;
  int                     errors, pending;
  int                     idle_cycles = 0;

  dsf_in_if  in_chan ();
  dsf_out_if out_chan ();

  damped_spring_force i_dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  dsf_checker i_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_chan), .out_mon(out_chan),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Request acceptance as seen at the last rising edge.
  always @(posedge clk) in_fire <= in_chan.valid && in_chan.ready;

  // Watchdog on cycles in which nothing moves on either channel or the register port.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) || psel)
      idle_cycles <= 0;
    else if (idle_cycles >= WDOG_MAX) begin
      $display("Simulation FAILED");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // Receiver: random stall bursts, one long hold-off on request, none at the end.
  initial begin
    int stall_left;
    stall_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else if (long_hold) begin
        long_hold  = 1'b0;
        stall_left = 299;
        out_chan.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_chan.ready <= 1'b0;
      end else
        out_chan.ready <= 1'b1;
    end
  end

  // Byte address of a configuration register.
  function automatic logic [dsf_pkg::AW-1:0] reg_addr(logic [1:0] idx);
    return {idx, 2'b00};
  endfunction

  // Random signed value within +-2^bits.
  function automatic logic [dsf_pkg::IW-1:0] rand_span(int bits);
    logic signed [dsf_pkg::IW-1:0] v;
    v = $urandom;
    return v >>> (31 - bits);
  endfunction

  function automatic dsf_pkg::item_t rand_spring();
    dsf_pkg::item_t it;
    int             mode, pb, vb;
    mode = $urandom_range(0, 9);
    pb   = $urandom_range(0, 24);
    vb   = $urandom_range(0, 31);
    it   = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    if (mode < 6) begin
      // Ordinary spring: nearby nodes, moderate velocities.
      it.pos_a_x = rand_span(24); it.pos_a_y = rand_span(24); it.pos_a_z = rand_span(24);
      it.pos_b_x = it.pos_a_x + rand_span(pb);
      it.pos_b_y = it.pos_a_y + rand_span(pb);
      it.pos_b_z = it.pos_a_z + rand_span(pb);
      it.vel_a_x = rand_span(vb); it.vel_a_y = rand_span(vb); it.vel_a_z = rand_span(vb);
      it.vel_b_x = rand_span(vb); it.vel_b_y = rand_span(vb); it.vel_b_z = rand_span(vb);
    end else if (mode == 7) begin
      // Coincident nodes.
      it.pos_b_x = it.pos_a_x; it.pos_b_y = it.pos_a_y; it.pos_b_z = it.pos_a_z;
    end else if (mode == 8) begin
      // Very short spring, a few LSBs apart.
      it.pos_b_x = it.pos_a_x + $urandom_range(0, 3) - 1;
      it.pos_b_y = it.pos_a_y + $urandom_range(0, 3) - 1;
      it.pos_b_z = it.pos_a_z + $urandom_range(0, 3) - 1;
    end
    return it;
  endfunction

  // Offer one request and hold it until it is accepted.
  task automatic send_spring(dsf_pkg::item_t it);
    in_chan.valid   <= 1'b1;
    in_chan.pos_a_x <= it.pos_a_x; in_chan.pos_a_y <= it.pos_a_y; in_chan.pos_a_z <= it.pos_a_z;
    in_chan.pos_b_x <= it.pos_b_x; in_chan.pos_b_y <= it.pos_b_y; in_chan.pos_b_z <= it.pos_b_z;
    in_chan.vel_a_x <= it.vel_a_x; in_chan.vel_a_y <= it.vel_a_y; in_chan.vel_a_z <= it.vel_a_z;
    in_chan.vel_b_x <= it.vel_b_x; in_chan.vel_b_y <= it.vel_b_y; in_chan.vel_b_z <= it.vel_b_z;
    do @(negedge clk); while (!in_fire);
  endtask

  // Sender gap, then the request.
  task automatic offer(dsf_pkg::item_t it);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    send_spring(it);
  endtask

  task automatic reg_write(logic [dsf_pkg::AW-1:0] addr, logic [dsf_pkg::IW-1:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Drain all results, let the pipeline empty, then load new constants.
  task automatic set_constants(logic [dsf_pkg::IW-1:0] k, logic [dsf_pkg::IW-1:0] c,
                               logic [dsf_pkg::IW-1:0] rest);
    in_chan.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (LATENCY + 10) @(negedge clk);
    reg_write(reg_addr(dsf_pkg::REG_STIFFNESS), k);
    reg_write(reg_addr(dsf_pkg::REG_DAMPING), c);
    reg_write(reg_addr(dsf_pkg::REG_REST_LENGTH), rest);
    reg_write(SPARE_ADDR, $urandom);
  endtask

  initial begin
    dsf_pkg::item_t it;
    in_chan.valid = 1'b0;
    {in_chan.pos_a_x, in_chan.pos_a_y, in_chan.pos_a_z, in_chan.pos_b_x, in_chan.pos_b_y,
     in_chan.pos_b_z, in_chan.vel_a_x, in_chan.vel_a_y, in_chan.vel_a_z, in_chan.vel_b_x,
     in_chan.vel_b_y, in_chan.vel_b_z} = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed springs under the reset constants.
    send_spring('0);
    it = '0; it.pos_a_x = 32'h0001_0000; send_spring(it);
    it = '0; it.pos_a_x = 32'h7fff_ffff; it.pos_b_x = 32'h8000_0000; send_spring(it);
    it = '0; it.pos_a_y = 32'h8000_0000; it.pos_b_y = 32'h7fff_ffff; send_spring(it);
    it = {12{32'h7fff_ffff}}; it.pos_b_x = 32'h8000_0000; it.pos_b_y = 32'h8000_0000;
    it.pos_b_z = 32'h8000_0000; it.vel_b_x = 32'h8000_0000; it.vel_b_y = 32'h8000_0000;
    it.vel_b_z = 32'h8000_0000; send_spring(it);
    it = {12{32'h8000_0000}}; send_spring(it);
    it = {12{32'hffff_ffff}}; it.pos_b_z = 32'h0; send_spring(it);
    it = '0; it.pos_a_z = 32'h0000_0001; send_spring(it);
    it = '0; it.pos_a_x = 32'h0000_d99a; send_spring(it);
    it = '0; it.pos_a_x = 32'h0001_0000; it.vel_a_x = 32'h7fff_ffff;
    it.vel_b_x = 32'h8000_0000; send_spring(it);
    it = '0; it.pos_a_x = 32'h0001_0000; it.vel_a_x = 32'h8000_0000;
    it.vel_b_x = 32'h7fff_ffff; send_spring(it);
    it = '0; it.pos_a_x = 32'h0000_8000; it.pos_a_y = 32'hffff_8000; it.pos_a_z = 32'h0000_8000;
    it.vel_a_y = 32'h0002_0000; send_spring(it);
    it = {12{32'h5555_5555}}; send_spring(it);
    it = {12{32'haaaa_aaaa}}; it.pos_b_x = 32'h5555_5555; send_spring(it);

    // Random springs over several sets of constants.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: set_constants('0, '0, '0);
        2: set_constants('1, '1, '1);
        3: set_constants(32'd1, 32'd1, '0);
        4: set_constants($urandom, $urandom, $urandom);
        5: begin
          set_constants($urandom_range(0, 32'h0010_0000), $urandom_range(0, 32'h0010_0000),
                        $urandom_range(0, 32'h0040_0000));
          quiet = 1'b1;
        end
        default: ;
      endcase
      for (int n = 0; n < 306; n++) begin
        if (ph == 0 && n == 100) long_hold = 1'b1;
        offer(rand_spring());
      end
    end
    in_chan.valid <= 1'b0;

    // Drain and settle.
    do @(negedge clk); while (pending != 0);
    repeat (LATENCY + 10) @(negedge clk);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule

// ----- files.f -----
design/dsf_pkg.sv
design/dsf_if.sv
design/dsf_front.sv
design/dsf_sqrt.sv
design/dsf_div.sv
design/dsf_force.sv
design/damped_spring_force.sv
tb/dsf_checker.sv
tb/tb_top.sv
